### hdl/tprb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed packet ring buffer package
// Operation codes, result kinds, field widths and register indexes.
// ----------------------------------------------------------------------------
package tprb_pkg;

    localparam int OP_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int TICK_W     = 16;
    localparam int LEN_W      = 7;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 3;
    localparam int AGE_W      = 32;
    localparam int CT_W       = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [LEN_W-1:0]  t_len;

    localparam t_op OP_WRITE = 3'd0;
    localparam t_op OP_TICK  = 3'd1;
    localparam t_op OP_FLUSH = 3'd2;
    localparam t_op OP_READ  = 3'd3;
    localparam t_op OP_PEEK  = 3'd4;

    localparam t_kind KIND_CLOSE = 2'd0;
    localparam t_kind KIND_DATA  = 2'd1;
    localparam t_kind KIND_EMPTY = 2'd2;

    localparam logic REG_CLOSE_TIME = 1'b0;

endpackage

### hdl/timed_packet_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed packet ring buffer
// Collects bytes into a ring of packet slots held in a packet memory, closes
// slots when full, on flush or on an age timeout, and streams out the oldest
// closed packet on read or peek.
// ----------------------------------------------------------------------------
// The block works on one transaction at a time. A tick or flush passes the
// execute state; a byte write passes execute and store, and the full state
// too when the byte fills its slot; a timer close ahead of the byte adds no
// state. A read or peek passes execute, then streams the packet from the
// registered read port of the packet memory, issuing each next read while the
// byte before it is emitted; with nothing to read it ends in execute. An
// unknown operation is dropped in idle. A result waits in the output register
// while the master side stalls. The memories need no clearing after reset.
// ----------------------------------------------------------------------------
module timed_packet_ring_buffer #(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_BYTES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // data_byte [7:0], tick_amount [23:8], read_limit [30:24], zero [31]
    input  logic [tprb_pkg::S_TDATA_W-1:0]       s_tdata,
    // op [2:0]
    input  logic [tprb_pkg::OP_W-1:0]            s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // slot_index [2:0], packet_length [9:3], out_byte [17:10],
    // overflow [18], zero [23:19]
    output logic [tprb_pkg::M_TDATA_W-1:0]       m_tdata,
    // kind [1:0]
    output logic [tprb_pkg::KIND_W-1:0]          m_tuser,
    output logic                                 m_tlast,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tprb_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tprb_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tprb_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import tprb_pkg::*;

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0]    SB_A      = AW'(SLOT_BYTES);
    localparam logic [SW-1:0]    LAST_SLOT = SW'(SLOT_COUNT - 1);
    localparam logic [SW-1:0]    MAX_HELD  = SW'(SLOT_COUNT - 1);
    localparam t_len             SB_LEN    = LEN_W'(SLOT_BYTES);
    localparam logic             TC_LAST   = (SLOT_BYTES != 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;

    function automatic logic [SW-1:0] f_next_slot(input logic [SW-1:0] s);
        if (s == LAST_SLOT) begin
            return '0;
        end
        return s + SW'(1);
    endfunction

    logic [2:0]        r_state, n_state;
    t_op               r_op, n_op;
    logic [BYTE_W-1:0] r_byte, n_byte;
    t_len              r_limit, n_limit;
    logic [AGE_W-1:0]  r_age, n_age;
    logic [CT_W-1:0]   r_close_time;
    logic [SW-1:0]     r_write_slot, n_write_slot;
    logic [SW-1:0]     r_read_slot, n_read_slot;
    t_len              r_fill, n_fill;
    logic [SW-1:0]     r_held, n_held;
    t_len              r_len, n_len;
    t_len              r_num, n_num;
    t_len              r_issue, n_issue;
    logic              r_q_valid, n_q_valid;

    logic              r_out_valid, n_out_valid;
    t_kind             r_out_kind, n_out_kind;
    logic [SW-1:0]     r_out_slot, n_out_slot;
    t_len              r_out_len, n_out_len;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              r_out_ovf, n_out_ovf;

    logic [BYTE_W-1:0] r_pkt_mem [DEPTH];
    logic [BYTE_W-1:0] r_mem_q;
    t_len              r_len_mem [SLOT_COUNT];
    t_len              r_len_q;

    logic              w_accept;
    logic              w_out_free;
    logic              w_timer_hit;
    logic              w_do_close;
    logic              w_close_last;
    logic              w_mem_we;
    logic              w_mem_re;
    logic              w_rd_emit;
    logic              w_rd_issue;
    logic              w_rd_done;
    logic [AGE_W:0]    w_age_sum;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic              w_cfg_we;

    assign s_tready   = (r_state == ST_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_out_valid || m_tready;
    assign w_age_sum  = {1'b0, r_age} + (AGE_W + 1)'(s_tdata[23:8]);
    assign w_timer_hit = (r_fill != '0) && (r_close_time != '0) &&
                         (r_age >= AGE_W'(r_close_time));
    assign w_waddr = AW'(r_write_slot) * SB_A + AW'(r_fill);
    assign w_raddr = AW'(r_read_slot) * SB_A + AW'(r_issue);
    assign w_rd_emit  = (r_state == ST_READ) && r_q_valid && w_out_free;
    assign w_rd_issue = (r_state == ST_READ) && (r_issue < r_num) &&
                        (!r_q_valid || w_rd_emit);
    assign w_rd_done  = w_rd_emit && (r_issue == r_num);

    assign w_cfg_we = psel && penable && pwrite && pready &&
                      (paddr[2] == REG_CLOSE_TIME);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CLOSE_TIME) ?
                      APB_DATA_W'(r_close_time) : '0;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_byte       = r_byte;
        n_limit      = r_limit;
        n_age        = r_age;
        n_write_slot = r_write_slot;
        n_read_slot  = r_read_slot;
        n_fill       = r_fill;
        n_held       = r_held;
        n_len        = r_len;
        n_num        = r_num;
        n_issue      = r_issue;
        n_q_valid    = r_q_valid;
        n_out_valid  = r_out_valid && !m_tready;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_len    = r_out_len;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_ovf    = r_out_ovf;
        w_do_close   = 1'b0;
        w_close_last = 1'b1;
        w_mem_we     = 1'b0;
        w_mem_re     = w_rd_issue;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op    = s_tuser;
                    n_byte  = s_tdata[7:0];
                    n_limit = s_tdata[30:24];
                    if (s_tuser == OP_TICK) begin
                        n_age = w_age_sum[AGE_W] ? '1 : w_age_sum[AGE_W-1:0];
                    end
                    if (s_tuser inside {[OP_WRITE:OP_PEEK]}) begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                case (r_op)
                    OP_WRITE: begin
                        if (!w_timer_hit) begin
                            n_state = ST_STORE;
                        end else if (w_out_free) begin
                            w_do_close   = 1'b1;
                            w_close_last = TC_LAST;
                            n_state      = ST_STORE;
                        end
                    end
                    OP_TICK: begin
                        if (!w_timer_hit) begin
                            n_state = ST_IDLE;
                        end else if (w_out_free) begin
                            w_do_close = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end
                    OP_FLUSH: begin
                        if (r_fill == '0) begin
                            n_state = ST_IDLE;
                        end else if (w_out_free) begin
                            w_do_close = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end
                    OP_READ, OP_PEEK: begin
                        if (r_held == '0 || r_limit == '0) begin
                            if (w_out_free) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = KIND_EMPTY;
                                n_out_slot  = r_read_slot;
                                n_out_len   = '0;
                                n_out_byte  = '0;
                                n_out_last  = 1'b1;
                                n_out_ovf   = 1'b0;
                                n_state     = ST_IDLE;
                            end
                        end else begin
                            n_len     = r_len_q;
                            n_num     = (r_len_q < r_limit) ? r_len_q : r_limit;
                            n_issue   = '0;
                            n_q_valid = 1'b0;
                            n_state   = ST_READ;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_STORE: begin
                w_mem_we = 1'b1;
                n_fill   = r_fill + LEN_W'(1);
                n_state  = (r_fill + LEN_W'(1) >= SB_LEN) ? ST_FULL : ST_IDLE;
            end
            ST_FULL: begin
                if (w_out_free) begin
                    w_do_close = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_READ: begin
                if (w_rd_issue) begin
                    n_issue   = r_issue + LEN_W'(1);
                    n_q_valid = 1'b1;
                end else if (w_rd_emit) begin
                    n_q_valid = 1'b0;
                end
                if (w_rd_emit) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_DATA;
                    n_out_slot  = r_read_slot;
                    n_out_len   = r_len;
                    n_out_byte  = r_mem_q;
                    n_out_last  = w_rd_done;
                    n_out_ovf   = 1'b0;
                end
                if (w_rd_done) begin
                    n_state = ST_IDLE;
                    if (r_op == OP_READ) begin
                        n_read_slot = f_next_slot(r_read_slot);
                        n_held      = r_held - SW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_do_close) begin
            n_out_valid  = 1'b1;
            n_out_kind   = KIND_CLOSE;
            n_out_slot   = r_write_slot;
            n_out_len    = r_fill;
            n_out_byte   = '0;
            n_out_last   = w_close_last;
            n_write_slot = f_next_slot(r_write_slot);
            n_fill       = '0;
            n_age        = '0;
            if (r_held == MAX_HELD) begin
                n_read_slot = f_next_slot(r_read_slot);
                n_held      = MAX_HELD;
                n_out_ovf   = 1'b1;
            end else begin
                n_held    = r_held + SW'(1);
                n_out_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_age        <= '0;
            r_close_time <= '0;
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_fill       <= '0;
            r_held       <= '0;
            r_q_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_age        <= n_age;
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_fill       <= n_fill;
            r_held       <= n_held;
            r_q_valid    <= n_q_valid;
            r_out_valid  <= n_out_valid;
            if (w_cfg_we) begin
                r_close_time <= pwdata[CT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_byte     <= n_byte;
        r_limit    <= n_limit;
        r_len      <= n_len;
        r_num      <= n_num;
        r_issue    <= n_issue;
        r_out_kind <= n_out_kind;
        r_out_slot <= n_out_slot;
        r_out_len  <= n_out_len;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_pkt_mem[w_waddr] <= r_byte;
        end
        if (w_mem_re) begin
            r_mem_q <= r_pkt_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_close) begin
            r_len_mem[r_write_slot] <= r_fill;
        end
        r_len_q <= r_len_mem[r_read_slot];
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_kind;
    assign m_tlast  = r_out_last;
    assign m_tdata  = {5'b0, r_out_ovf, r_out_byte, r_out_len, SLOT_W'(r_out_slot)};

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_fill < SB_LEN))
        else $error("slot fill reached the slot size while idle");

    a_read_needs_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_held != '0) && (r_num != '0))
        else $error("packet streaming without a closed packet");

    a_overflow_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_kind == KIND_CLOSE))
        else $error("overflow flag on a result that is not a close event");

    a_close_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_close |=> (r_held != '0) && (r_fill == '0) && (r_age == '0))
        else $error("close did not empty the fill slot or record the packet");

endmodule
